// ===== sv/mrwr_pkg.sv =====
// Shared types and constants for the Miller-Rabin witness round block.
package mrwr_pkg;

  localparam int unsigned MR_WIDTH = 32;

  localparam logic [1:0] VERDICT_COMPOSITE = 2'd0;
  localparam logic [1:0] VERDICT_PRIME     = 2'd1;
  localparam logic [1:0] VERDICT_RANGE     = 2'd2;

  typedef enum logic {
    MUL_DST_R,
    MUL_DST_B
  } mul_dst_e;

  typedef struct packed {
    logic     load;
    logic     pow_init;
    logic     mul_start;
    mul_dst_e mul_dst;
    logic     e_shift;
    logic     u_shift;
  } mrwr_cmd_t;

  typedef struct packed {
    logic p_lt2;
    logic p_eq2;
    logic a_bad;
    logic e_zero;
    logic e_lsb;
    logic u_lsb;
    logic r_one;
    logic r_pm1;
    logic mul_done;
  } mrwr_sts_t;

endpackage

// ===== sv/mrwr_mulmod.sv =====
// Shift-and-add modular multiplier, one multiplier bit per cycle.
module mrwr_mulmod import mrwr_pkg::*; #(
  parameter int unsigned WIDTH = MR_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  input  logic [WIDTH-1:0] m_i,
  output logic             done_o,
  output logic [WIDTH-1:0] prod_o
);

  logic             busy_q, busy_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] y_q, y_d;
  logic [WIDTH-1:0] room;
  logic [WIDTH-1:0] acc_add;
  logic [WIDTH-1:0] x_dbl;

  assign room    = m_i - x_q;
  assign acc_add = (acc_q >= room) ? (acc_q - room) : (acc_q + x_q);
  assign x_dbl   = (x_q >= room) ? (x_q - room) : (x_q + x_q);

  assign done_o = busy_q && (y_q == '0);
  assign prod_o = acc_q;

  always_comb begin
    busy_d = busy_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    if (start_i) begin
      busy_d = 1'b1;
      acc_d  = '0;
      x_d    = x_i;
      y_d    = y_i;
    end else if (busy_q) begin
      if (y_q == '0) begin
        busy_d = 1'b0;
      end else begin
        if (y_q[0]) begin
          acc_d = acc_add;
        end
        x_d = x_dbl;
        y_d = y_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (acc_q < m_i) && (x_q < m_i))
    else $error("mulmod operand not reduced");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q || done_o)
    else $error("mulmod restarted while busy");

endmodule

// ===== sv/mrwr_dp.sv =====
// Datapath: operand, exponent and power registers around the modular multiplier.
module mrwr_dp import mrwr_pkg::*; #(
  parameter int unsigned WIDTH = MR_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIDTH-1:0] candidate_i,
  input  logic [WIDTH-1:0] witness_i,
  input  mrwr_cmd_t        cmd_i,
  output mrwr_sts_t        sts_o
);

  logic [WIDTH-1:0] p_q, a_q, u_q, e_q, r_q, b_q;
  logic [WIDTH-1:0] p_m1;
  logic [WIDTH-1:0] mul_y;
  logic [WIDTH-1:0] prod;
  logic             mul_done;
  mul_dst_e         dst_q;

  assign p_m1  = p_q - WIDTH'(1);
  assign mul_y = (cmd_i.mul_dst == MUL_DST_R) ? r_q : b_q;

  mrwr_mulmod #(
    .WIDTH(WIDTH)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .x_i    (b_q),
    .y_i    (mul_y),
    .m_i    (p_q),
    .done_o (mul_done),
    .prod_o (prod)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q <= candidate_i;
      a_q <= witness_i;
      u_q <= candidate_i - WIDTH'(1);
    end else if (cmd_i.u_shift) begin
      u_q <= u_q >> 1;
    end
    if (cmd_i.pow_init) begin
      r_q <= WIDTH'(1);
      b_q <= a_q;
      e_q <= u_q;
    end else begin
      if (mul_done && dst_q == MUL_DST_R) begin
        r_q <= prod;
      end
      if (mul_done && dst_q == MUL_DST_B) begin
        b_q <= prod;
      end
      if (cmd_i.e_shift) begin
        e_q <= e_q >> 1;
      end
    end
    if (cmd_i.mul_start) begin
      dst_q <= cmd_i.mul_dst;
    end
  end

  always_comb begin
    sts_o.p_lt2    = (p_q[WIDTH-1:1] == '0);
    sts_o.p_eq2    = (p_q == WIDTH'(2));
    sts_o.a_bad    = (a_q == '0) || (a_q >= p_q);
    sts_o.e_zero   = (e_q == '0);
    sts_o.e_lsb    = e_q[0];
    sts_o.u_lsb    = u_q[0];
    sts_o.r_one    = (r_q == WIDTH'(1));
    sts_o.r_pm1    = (r_q == p_m1);
    sts_o.mul_done = mul_done;
  end

endmodule

// ===== sv/mrwr_ctrl.sv =====
// Controller: sequences the power computations and the halving loop, owns the handshakes.
module mrwr_ctrl import mrwr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] verdict_o,
  output mrwr_cmd_t  cmd_o,
  input  mrwr_sts_t  sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_POW_INIT,
    S_POW_TEST,
    S_MUL_R,
    S_MUL_B,
    S_POW_END,
    S_DONE
  } state_e;

  state_e     state_q, state_d;
  logic       first_q, first_d;
  logic [1:0] res_q, res_d;
  logic [1:0] verdict_q, verdict_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    res_d       = res_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.p_lt2) begin
          res_d   = VERDICT_COMPOSITE;
          state_d = S_DONE;
        end else if (sts_i.p_eq2) begin
          res_d   = VERDICT_PRIME;
          state_d = S_DONE;
        end else if (sts_i.a_bad) begin
          res_d   = VERDICT_RANGE;
          state_d = S_DONE;
        end else begin
          first_d = 1'b1;
          state_d = S_POW_INIT;
        end
      end
      S_POW_INIT: begin
        cmd_o.pow_init = 1'b1;
        state_d        = S_POW_TEST;
      end
      S_POW_TEST: begin
        if (sts_i.e_zero) begin
          state_d = S_POW_END;
        end else if (sts_i.e_lsb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_dst   = MUL_DST_R;
          state_d         = S_MUL_R;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_dst   = MUL_DST_B;
          state_d         = S_MUL_B;
        end
      end
      S_MUL_R: begin
        if (sts_i.mul_done) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_dst   = MUL_DST_B;
          state_d         = S_MUL_B;
        end
      end
      S_MUL_B: begin
        if (sts_i.mul_done) begin
          cmd_o.e_shift = 1'b1;
          state_d       = S_POW_TEST;
        end
      end
      S_POW_END: begin
        if (!sts_i.r_one && (first_q || !sts_i.r_pm1)) begin
          res_d   = VERDICT_COMPOSITE;
          state_d = S_DONE;
        end else if (!sts_i.u_lsb && sts_i.r_one) begin
          cmd_o.u_shift = 1'b1;
          first_d       = 1'b0;
          state_d       = S_POW_INIT;
        end else begin
          res_d   = VERDICT_PRIME;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          verdict_d   = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_q     <= 1'b0;
      res_q       <= VERDICT_COMPOSITE;
      verdict_q   <= VERDICT_COMPOSITE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      res_q       <= res_d;
      verdict_q   <= verdict_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |-> (state_q == S_MUL_R) || (state_q == S_MUL_B))
    else $error("multiplier finished outside a wait state");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !$rose(out_valid_q))
    else $error("result raised right after request");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (verdict_q == VERDICT_COMPOSITE) || (verdict_q == VERDICT_PRIME) ||
                    (verdict_q == VERDICT_RANGE))
    else $error("undefined verdict code");

  a_shift_in_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.u_shift |-> sts_i.r_one && !sts_i.u_lsb)
    else $error("exponent halved without a unit power");

endmodule

// ===== sv/miller_rabin_witness_round.sv =====
// Top level of the Miller-Rabin witness round: controller plus datapath.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, candidate_i,      | request in
//          | witness_i                                 |
//  out     | out_valid_o, out_ready_i, verdict_o       | result out
//
// One request at a time. Small candidates and a bad witness go from the check state straight
// to the result. Otherwise each power a^e mod p starts with an init step and then, per bit of
// e, a test step and one or two modular products on the single shared shift-and-add
// multiplier, ending in a check of the power; up to s+1 powers run, s being the halvings of
// p-1 (at most WIDTH-1).
// Reset clears the controller and drops any pending result.
// A stalled result holds in the output register while the next request is already accepted.
module miller_rabin_witness_round import mrwr_pkg::*; #(
  parameter int unsigned WIDTH = MR_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] candidate_i,
  input  logic [WIDTH-1:0] witness_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       verdict_o
);

  mrwr_cmd_t cmd;
  mrwr_sts_t sts;

  mrwr_dp #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .candidate_i(candidate_i),
    .witness_i  (witness_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

  mrwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .verdict_o  (verdict_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

endmodule

// ===== test/tb_miller_rabin_witness_round.sv =====
// Testbench for the Miller-Rabin witness round: checks every verdict against its own predictor.
module tb_miller_rabin_witness_round import mrwr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [MR_WIDTH-1:0] word_t;

  typedef struct {
    word_t      cand;
    word_t      wit;
    logic [1:0] verdict;
  } round_t;

  class verdict_board;
    round_t      awaited[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned requests;
    int unsigned verdict_count[4];

    function bit [63:0] residue_power(bit [63:0] b, bit [63:0] e, bit [63:0] m);
      bit [63:0] r;
      r = 64'd1 % m;
      while (e != 0) begin
        if (e[0]) r = (r * b) % m;
        b = (b * b) % m;
        e = e >> 1;
      end
      return r;
    endfunction

    function logic [1:0] round_verdict(word_t cand, word_t wit);
      bit [63:0] p;
      bit [63:0] a;
      bit [63:0] u;
      bit [63:0] q;
      p = cand;
      a = wit;
      if (p < 2) return VERDICT_COMPOSITE;
      if (p == 2) return VERDICT_PRIME;
      if (a == 0 || a >= p) return VERDICT_RANGE;
      if (residue_power(a, p - 1, p) != 1) return VERDICT_COMPOSITE;
      u = p - 1;
      q = 1;
      while (!u[0] && q == 1) begin
        u = u >> 1;
        q = residue_power(a, u, p);
        if (q != 1 && q != p - 1) return VERDICT_COMPOSITE;
      end
      return VERDICT_PRIME;
    endfunction

    function void note_request(word_t cand, word_t wit);
      round_t r;
      r.cand    = cand;
      r.wit     = wit;
      r.verdict = round_verdict(cand, wit);
      awaited.push_back(r);
      requests++;
      verdict_count[r.verdict]++;
    endfunction

    function void check_verdict(logic [1:0] actual);
      round_t r;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected verdict %0d with no request pending", actual);
        return;
      end
      r = awaited.pop_front();
      checked++;
      if (actual !== r.verdict) begin
        mismatches++;
        if (mismatches <= 10)
          $display("verdict mismatch: candidate %0d witness %0d expected %0d got %0d",
                   r.cand, r.wit, r.verdict, actual);
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  word_t      candidate_i = '0;
  word_t      witness_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] verdict_o;

  verdict_board board;
  bit           gaps_on   = 1'b1;
  bit           stalls_on = 1'b1;

  word_t carmichael[16] = '{561, 1105, 1729, 2465, 2821, 6601, 8911, 10585,
                            15841, 29341, 41041, 46657, 52633, 62745, 63973, 75361};

  miller_rabin_witness_round DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .candidate_i (candidate_i),
    .witness_i   (witness_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .verdict_o   (verdict_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_verdict(verdict_o);
  end

  initial begin
    @(posedge clk_i iff rst_ni);
    forever begin
      if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic send_request(input word_t cand, input word_t wit);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    candidate_i <= cand;
    witness_i   <= wit;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(cand, wit);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Random prime of the given bit length; bases 2, 7 and 61 settle every 32-bit odd number.
  function automatic word_t draw_prime(int unsigned bits);
    bit [63:0] mask;
    bit [63:0] p;
    bit [63:0] base;
    bit        ok;
    int        bases[3] = '{2, 7, 61};
    mask = (64'd1 << bits) - 1;
    do begin
      p = {32'd0, $urandom()} & mask;
      p[bits-1] = 1'b1;
      p[0]      = 1'b1;
      ok = 1'b1;
      foreach (bases[i]) begin
        base = bases[i] % p;
        if (base != 0 &&
            board.round_verdict(p[MR_WIDTH-1:0], base[MR_WIDTH-1:0]) != VERDICT_PRIME)
          ok = 1'b0;
      end
    end while (!ok);
    return p[MR_WIDTH-1:0];
  endfunction

  task automatic random_request();
    word_t       cand;
    word_t       wit;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      cand = draw_prime($urandom_range(32, 2));
      wit  = ($urandom_range(0, 9) == 0) ? cand - 1 : $urandom_range(cand - 1, 1);
    end else if (pick < 55) begin
      cand = carmichael[$urandom_range(15, 0)];
      wit  = $urandom_range(cand - 1, 1);
    end else if (pick < 70) begin
      cand = $urandom() >> $urandom_range(30, 0);
      if (cand < 3) cand = 3;
      wit = $urandom_range(cand - 1, 1);
    end else if (pick < 85) begin
      cand = $urandom();
      wit  = $urandom();
    end else if (pick < 95) begin
      cand = $urandom_range(32'hffff_ffff, 3);
      wit  = ($urandom_range(0, 3) == 0) ? '0 : $urandom_range(32'hffff_ffff, cand);
    end else begin
      cand = $urandom_range(2, 0);
      wit  = $urandom();
    end
    send_request(cand, wit);
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(32'd0, 32'd0);
    send_request(32'd1, 32'hffff_ffff);
    send_request(32'd2, 32'd0);
    send_request(32'd2, 32'hffff_ffff);
    send_request(32'd3, 32'd0);
    send_request(32'd3, 32'd3);
    send_request(32'hffff_ffff, 32'hffff_ffff);
    send_request(32'd3, 32'd2);
    send_request(32'd4, 32'd3);
    send_request(32'd9, 32'd8);
    send_request(32'd5, 32'd1);
    send_request(32'hffff_fffe, 32'd1);
    send_request(32'h8000_0000, 32'h7fff_ffff);
    send_request(32'h8000_0001, 32'd2);
    send_request(32'hffff_fffb, 32'd2);
    send_request(32'hffff_fffb, 32'hffff_fffa);
    send_request(32'hffff_ffff, 32'hffff_fffe);
    send_request(32'hffff_ffff, 32'd2);
    send_request(32'd561, 32'd2);
    send_request(32'd2047, 32'd2);
    send_request(32'd65537, 32'd3);
    send_request(32'd3215031751, 32'd2);
    send_request(32'd25326001, 32'd3);

    drain();

    for (int i = 0; i < 200; i++) begin
      if (i == 100) drain();
      if (i == 160) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      random_request();
    end

    drain();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d requests: %0d composite, %0d probable prime, %0d witness out of range",
             board.requests, board.verdict_count[VERDICT_COMPOSITE],
             board.verdict_count[VERDICT_PRIME], board.verdict_count[VERDICT_RANGE]);
    $display("Checked %0d verdicts, %0d mismatches", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
